>>> hw/rtl/fbpa_pkg.sv
// Shared types, widths and codes for the fixed block pool allocator.
package fbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int SCAN_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CNT_W      = 7;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int BCNT_W     = 7;
  localparam int CFG_IDX_W  = 2;

  typedef logic [1:0]           status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_NO_FREE = 2'd2;

  localparam cfg_idx_t REG_BASE_ADDRESS = 2'd0;
  localparam cfg_idx_t REG_BLOCK_SIZE   = 2'd1;
  localparam cfg_idx_t REG_BLOCK_COUNT  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic             start;
    logic             alloc;
    logic             clr;
    logic [IDX_W-1:0] clr_idx;
  } pool_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              clearing;
    logic              done;
    logic              found;
    logic [ADDR_W-1:0] addr;
    logic [SCAN_W-1:0] free_cnt;
  } pool_stat_t;

endpackage

>>> hw/rtl/fbpa_ifs.sv
// Valid/ready channel interfaces for requests, responses and configuration writes.
interface fbpa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [fbpa_pkg::ADDR_W-1:0] address;
  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

interface fbpa_rsp_if;
  logic                        valid;
  logic                        ready;
  fbpa_pkg::status_t           status;
  logic [fbpa_pkg::ADDR_W-1:0] block_address;
  logic [fbpa_pkg::CNT_W-1:0]  free_count;
  modport source (output valid, output status, output block_address, output free_count,
                  input ready);
  modport sink (input valid, input status, input block_address, input free_count,
                output ready);
endinterface

interface fbpa_cfg_if;
  logic                        valid;
  logic                        ready;
  fbpa_pkg::cfg_idx_t          index;
  logic [fbpa_pkg::ADDR_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/fbpa_divider.sv
// Serial restoring divider, one quotient bit per cycle.
module fbpa_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0]   divisor,
  output logic                          done,
  output logic [fbpa_pkg::ADDR_W-1:0]   quotient,
  output logic [fbpa_pkg::SIZE_W-1:0]   remainder
);
  import fbpa_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;

  assign trial = {remainder, quotient[ADDR_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !start && (step == STEP_W'(ADDR_W - 1));
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        dvs       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (diff[SIZE_W]) begin
          remainder <= trial[SIZE_W-1:0];
          quotient  <= {quotient[ADDR_W-2:0], 1'b0};
        end else begin
          remainder <= diff[SIZE_W-1:0];
          quotient  <= {quotient[ADDR_W-2:0], 1'b1};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hw/rtl/fbpa_pool.sv
// Used-bit memory with a one-block-per-cycle scan for allocation and free counting.
module fbpa_pool (
  input  logic                          clk,
  input  logic                          rst,
  input  fbpa_pkg::pool_cmd_t           cmd,
  input  logic [fbpa_pkg::SCAN_W-1:0]   usable,
  input  logic [fbpa_pkg::ADDR_W-1:0]   base,
  input  logic [fbpa_pkg::SIZE_W-1:0]   size,
  input  logic [fbpa_pkg::IDX_W-1:0]    rd_idx,
  output logic                          rd_used,
  output fbpa_pkg::pool_stat_t          stat
);
  import fbpa_pkg::*;

  logic              used [MAX_BLOCKS];
  logic [SCAN_W-1:0] idx;
  logic [IDX_W-1:0]  ix;
  logic [IDX_W-1:0]  pos;
  logic              pend;
  logic              scan_used;
  logic [ADDR_W-1:0] acc;
  logic              alloc;
  logic [IDX_W-1:0]  clr_cnt;
  logic              take;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_val;

  assign ix   = idx[IDX_W-1:0];
  assign take = stat.busy && pend && !scan_used && alloc && !stat.found;

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = cmd.clr_idx;
    wr_val = 1'b0;
    if (stat.clearing) begin
      wr_en  = 1'b1;
      wr_idx = clr_cnt;
    end else if (cmd.clr) begin
      wr_en  = 1'b1;
    end else if (take) begin
      wr_en  = 1'b1;
      wr_idx = pos;
      wr_val = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used[wr_idx] <= wr_val;
    end
    rd_used   <= used[rd_idx];
    scan_used <= used[ix];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy     <= 1'b0;
      stat.clearing <= 1'b1;
      stat.done     <= 1'b0;
      stat.found    <= 1'b0;
      clr_cnt       <= '0;
      idx           <= '0;
      pend          <= 1'b0;
    end else begin
      stat.done <= !cmd.start && stat.busy && (idx == usable);
      if (stat.clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == IDX_W'(MAX_BLOCKS - 1)) begin
          stat.clearing <= 1'b0;
        end
      end
      if (cmd.start) begin
        stat.busy     <= 1'b1;
        stat.found    <= 1'b0;
        stat.free_cnt <= '0;
        stat.addr     <= '0;
        idx           <= '0;
        pend          <= 1'b0;
        acc           <= base;
        alloc         <= cmd.alloc;
      end else if (stat.busy) begin
        if (idx != usable) begin
          idx  <= idx + 1'b1;
          pos  <= ix;
          pend <= 1'b1;
        end else begin
          pend      <= 1'b0;
          stat.busy <= 1'b0;
        end
        if (pend) begin
          acc <= acc + {{(ADDR_W-SIZE_W){1'b0}}, size};
          if (!scan_used) begin
            if (alloc && !stat.found) begin
              stat.found <= 1'b1;
              stat.addr  <= acc;
            end else begin
              stat.free_cnt <= stat.free_cnt + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

>>> hw/rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: configuration, sequencer and response register.
//
// Usage:
//   cfg : register writes (index 0 base address, 1 block size, 2 block count); always ready;
//         written by the user only while no request is in flight, not enforced by the block.
//   req : kind 0 allocates the lowest free block, kind 1 frees the block at address.
//   rsp : status, block_address and free_count, one transfer per request.
// Sequence:
//   Allocate: the n = min(block count, 64) blocks are walked by the
//   one-block-per-cycle bitmap scan that both picks the block and counts free ones.
//   Free: the serial divider, one check state, then the same counting scan.
//   One request is worked at a time; req.ready is high only when the sequencer is idle.
// Reset: every block is free, base_address 0, block size 16, block count 64; a
//   pass over all 64 used bits clears them and holds req.ready low until it ends.
// Stall: a finished response is held in the output register; the next request
//   is taken meanwhile and its result waits until the held one transfers.
module fixed_block_pool_allocator (
  input  logic       clk,
  input  logic       rst,
  fbpa_cfg_if.sink   cfg,
  fbpa_req_if.sink   req,
  fbpa_rsp_if.source rsp
);
  import fbpa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state;
  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] blk_size;
  logic [BCNT_W-1:0] blk_count;
  logic [SCAN_W-1:0] usable;
  logic              kind;
  status_t           status_r;
  logic              precheck;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] quot;
  logic [SIZE_W-1:0] rem;
  logic              rd_used;
  logic              free_ok;
  pool_cmd_t         cmd;
  pool_stat_t        stat;

  assign usable = (32'(blk_count) > MAX_BLOCKS) ? SCAN_W'(MAX_BLOCKS)
                                                 : SCAN_W'(blk_count);
  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && !stat.clearing;

  assign precheck = (req.address != '0) && (req.address >= base_address) &&
                    (blk_size != '0);
  assign div_start = req.valid && req.ready && (req.kind == KIND_FREE) && precheck;
  assign free_ok   = (quot < 32'(usable)) && (rem == '0) && rd_used;

  always_comb begin
    cmd = '0;
    cmd.clr_idx = quot[IDX_W-1:0];
    if (req.valid && req.ready) begin
      if (req.kind == KIND_ALLOC) begin
        cmd.start = 1'b1;
        cmd.alloc = 1'b1;
      end else if (!precheck) begin
        cmd.start = 1'b1;
      end
    end
    if (state == S_CHECK) begin
      cmd.start = 1'b1;
      cmd.clr   = free_ok;
    end
  end

  fbpa_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.address - base_address),
    .divisor   (blk_size),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  fbpa_pool u_pool (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .usable  (usable),
    .base    (base_address),
    .size    (blk_size),
    .rd_idx  (quot[IDX_W-1:0]),
    .rd_used (rd_used),
    .stat    (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      blk_size     <= SIZE_W'(16);
      blk_count    <= BCNT_W'(MAX_BLOCKS);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_BASE_ADDRESS: base_address <= cfg.data;
        REG_BLOCK_SIZE:   blk_size     <= cfg.data[SIZE_W-1:0];
        REG_BLOCK_COUNT:  blk_count    <= cfg.data[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            kind <= req.kind;
            if (req.kind == KIND_ALLOC) begin
              state <= S_SCAN;
            end else if (precheck) begin
              state <= S_DIV;
            end else begin
              status_r <= ST_INVALID;
              state    <= S_SCAN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          status_r <= free_ok ? ST_OK : ST_INVALID;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.done) begin
            if (kind == KIND_ALLOC) begin
              status_r <= stat.found ? ST_OK : ST_NO_FREE;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid         <= 1'b1;
            rsp.status        <= status_r;
            rsp.block_address <= (kind == KIND_ALLOC && stat.found) ? stat.addr : '0;
            rsp.free_count    <= CNT_W'(stat.free_cnt);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("request transfer did not start the sequencer");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> state == S_SCAN)
    else $error("bitmap scan finished outside the scan phase");

  a_idle_pool_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !stat.busy)
    else $error("bitmap scan running while idle");

endmodule

>>> verif/fbpa_pool_checker.sv
// Checker for the fixed block pool allocator: tracks the pool bitmap and compares every response.
module fbpa_pool_checker (
  input  logic clk,
  input  logic rst,
  fbpa_cfg_if  cfg,
  fbpa_req_if  req,
  fbpa_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   ok_count,
  output int   reject_count,
  output int   full_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   block_address;
    logic [CNT_W-1:0]    free_count;
  } pool_result_t;

  logic [MAX_BLOCKS-1:0] used_map;
  logic [ADDR_W-1:0]     pool_base;
  logic [SIZE_W-1:0]     pool_size;
  logic [BCNT_W-1:0]     pool_count;
  pool_result_t          pending_results[$];

  task automatic predict_pool_op(input logic kind, input logic [ADDR_W-1:0] addr,
                                 output pool_result_t res);
    int unsigned       usable;
    int unsigned       free_blocks;
    logic              found;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] quotient;
    logic [ADDR_W-1:0] remainder;
    usable = (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : pool_count;
    res = '0;
    found = 1'b0;
    if (kind == KIND_ALLOC) begin
      res.status = ST_NO_FREE;
      for (int i = 0; i < usable; i++) begin
        if (!found && !used_map[i]) begin
          found = 1'b1;
          used_map[i] = 1'b1;
          res.status = ST_OK;
          res.block_address = pool_base + 32'(i) * {16'b0, pool_size};
        end
      end
    end else begin
      res.status = ST_INVALID;
      if (addr != '0 && addr >= pool_base && pool_size != '0) begin
        offset    = addr - pool_base;
        quotient  = offset / {16'b0, pool_size};
        remainder = offset % {16'b0, pool_size};
        if (quotient < usable && remainder == '0 && used_map[quotient]) begin
          used_map[quotient] = 1'b0;
          res.status = ST_OK;
        end
      end
    end
    free_blocks = 0;
    for (int i = 0; i < usable; i++) begin
      if (!used_map[i]) free_blocks++;
    end
    res.free_count = CNT_W'(free_blocks);
  endtask

  always @(posedge clk) begin
    pool_result_t want;
    pool_result_t got;
    if (rst) begin
      used_map   = '0;
      pool_base  = '0;
      pool_size  = 16'd16;
      pool_count = 7'd64;
      pending_results.delete();
      fail_count   = 0;
      ok_count     = 0;
      reject_count = 0;
      full_count   = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BASE_ADDRESS: pool_base  = cfg.data;
          REG_BLOCK_SIZE:   pool_size  = cfg.data[SIZE_W-1:0];
          REG_BLOCK_COUNT:  pool_count = cfg.data[BCNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.block_address, rsp.free_count};
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: expected no transfer, actual status %0d address %h free %0d",
                   $time, got.status, got.block_address, got.free_count);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          end
          if (got.block_address !== want.block_address) begin
            fail_count++;
            $display("%0t: block_address expected %h actual %h",
                     $time, want.block_address, got.block_address);
          end
          if (got.free_count !== want.free_count) begin
            fail_count++;
            $display("%0t: free_count expected %0d actual %0d",
                     $time, want.free_count, got.free_count);
          end
          case (want.status)
            ST_OK:      ok_count++;
            ST_INVALID: reject_count++;
            default:    full_count++;
          endcase
        end
      end
      if (req.valid && req.ready) begin
        predict_pool_op(req.kind, req.address, want);
        pending_results.push_back(want);
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> verif/fixed_block_pool_allocator_tb.sv
// Testbench top for the fixed block pool allocator: clock, reset, stimulus and verdict.
module fixed_block_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fbpa_pkg::*;

  localparam int       HOLD_CYCLES = 400;
  localparam int       PHASES      = 8;
  localparam int       PHASE_ITEMS = 100;
  localparam cfg_idx_t REG_UNUSED  = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic req_took = 1'b0;
  logic cfg_took = 1'b0;

  bit   gaps_on;
  bit   stalls_on;
  int   hold_requests;
  int   holds_done;
  int   alloc_sent;
  int   free_sent;
  int   settings_used;

  int   fail_count;
  int   pending;
  int   ok_count;
  int   reject_count;
  int   full_count;

  logic [ADDR_W-1:0] cur_base;
  logic [SIZE_W-1:0] cur_size;
  logic [BCNT_W-1:0] cur_count;

  fbpa_cfg_if cfg_ch ();
  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  fixed_block_pool_allocator u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  fbpa_pool_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_ch),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .ok_count     (ok_count),
    .reject_count (reject_count),
    .full_count   (full_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    req_took <= req_ch.valid && req_ch.ready;
    cfg_took <= cfg_ch.valid && cfg_ch.ready;
  end

  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr);
    if (gaps_on && $urandom_range(99) < 28) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.kind    <= kind;
    req_ch.address <= addr;
    do @(negedge clk); while (!req_took);
    if (kind == KIND_ALLOC) alloc_sent++;
    else free_sent++;
  endtask

  task automatic drain_pool();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [ADDR_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(negedge clk); while (!cfg_took);
  endtask

  task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size_val,
                          input logic [BCNT_W-1:0] count_val);
    drain_pool();
    write_reg(REG_BASE_ADDRESS, base);
    write_reg(REG_BLOCK_SIZE, {16'($urandom), size_val});
    write_reg(REG_BLOCK_COUNT, {25'($urandom), count_val});
    cfg_ch.valid <= 1'b0;
    cur_base  = base;
    cur_size  = size_val;
    cur_count = count_val;
    settings_used++;
  endtask

  task automatic random_setup(input int phase);
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size_val;
    logic [BCNT_W-1:0] count_val;
    base = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(4095) : $urandom;
    case ($urandom_range(3))
      0:       size_val = SIZE_W'($urandom_range(1, 16));
      1:       size_val = 16'd1 << $urandom_range(15);
      2:       size_val = SIZE_W'($urandom);
      default: size_val = SIZE_W'($urandom_range(1, 255));
    endcase
    count_val = BCNT_W'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                 : $urandom_range(1, 64));
    case (phase)
      0:       set_pool(32'h0, 16'd1, 7'd64);
      1:       set_pool(32'hFFFF_FFFF, 16'hFFFF, 7'd1);
      2:       set_pool(base, 16'hFFFF, 7'd127);
      3:       set_pool(32'hFFFF_FC00, 16'd64, 7'd40);
      default: set_pool(base, size_val, count_val);
    endcase
  endtask

  task automatic random_request();
    int unsigned       usable;
    int unsigned       slot;
    int unsigned       pick;
    logic [ADDR_W-1:0] addr;
    usable = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
    pick = $urandom_range(99);
    if (pick < 48) begin
      send_item(KIND_ALLOC, $urandom);
    end else begin
      slot = $urandom_range(usable + 1);
      addr = cur_base + slot * {16'b0, cur_size};
      if (pick >= 80) begin
        case ($urandom_range(3))
          0:       addr = '0;
          1:       addr = $urandom;
          2:       addr = addr + $urandom_range(1, (cur_size > 1) ? cur_size - 1 : 1);
          default: addr = cur_base - $urandom_range(1, 64);
        endcase
      end
      send_item(KIND_FREE, addr);
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < hold_requests) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (stalls_on && $urandom_range(99) < 28) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #6ms;
    $display("fixed_block_pool_allocator verification failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_BASE_ADDRESS;
    cfg_ch.data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.kind    = KIND_ALLOC;
    req_ch.address = '0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    hold_requests  = 0;
    holds_done     = 0;
    alloc_sent     = 0;
    free_sent      = 0;
    settings_used  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_pool(32'h0000_1000, 16'd16, 7'd4);
    repeat (5) send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, 32'h0000_0000);
    send_item(KIND_FREE, 32'h0000_0FF0);
    send_item(KIND_FREE, 32'h0000_1008);
    send_item(KIND_FREE, 32'h0000_1040);
    send_item(KIND_FREE, 32'hFFFF_FFFF);
    send_item(KIND_FREE, 32'h0000_1010);
    send_item(KIND_FREE, 32'h0000_1010);
    send_item(KIND_ALLOC, 32'hFFFF_FFFF);
    send_item(KIND_FREE, 32'h0000_1020);
    set_pool(32'h0000_1000, 16'd0, 7'd4);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, 32'h0000_1000);
    set_pool(32'h0000_1000, 16'd16, 7'd0);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, 32'h0000_1000);
    set_pool(32'hFFFF_FFF0, 16'd16, 7'd127);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_FREE, 32'h0000_0030);
    send_item(KIND_FREE, 32'hFFFF_FFF0);
    send_item(KIND_ALLOC, '0);
    drain_pool();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_BLOCK_COUNT, 32'd2);
    cfg_ch.valid <= 1'b0;
    cur_count = 7'd2;
    send_item(KIND_ALLOC, '0);

    for (int phase = 0; phase < PHASES; phase++) begin
      random_setup(phase);
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == 20) hold_requests++;
        if (phase == 5 && n == 50) drain_pool();
        random_request();
      end
    end

    drain_pool();
    repeat (120) @(negedge clk);
    $display("Sent %0d allocate and %0d free requests across %0d pool settings",
             alloc_sent, free_sent, settings_used);
    $display("Responses checked: %0d ok, %0d rejected frees, %0d with pool full",
             ok_count, reject_count, full_count);
    if (fail_count == 0) begin
      $display("fixed_block_pool_allocator verification clean");
    end else begin
      $display("fixed_block_pool_allocator verification failed");
    end
    $finish;
  end

endmodule

>>> fixed_block_pool_allocator.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ifs.sv
hw/rtl/fbpa_divider.sv
hw/rtl/fbpa_pool.sv
hw/rtl/fixed_block_pool_allocator.sv
verif/fbpa_pool_checker.sv
verif/fixed_block_pool_allocator_tb.sv
